>>> design/egress_flow_filter_defines.svh
// Assertion macros for the egress flow filter.
`ifndef EGRESS_FLOW_FILTER_DEFINES_SVH
`define EGRESS_FLOW_FILTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define EFF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define EFF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define EFF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define EFF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> design/eff_pkg.sv
`default_nettype none
package eff_pkg;
  localparam int RuleSlotsDef = 128;
  localparam int FlowSlotsDef = 128;

  localparam logic [15:0] EthertypeIpv4 = 16'h0800;
  localparam logic [15:0] EthMinLen = 16'd14;
  localparam logic [15:0] IpMinLen = 16'd34;
  localparam logic [15:0] L4MinLen = 16'd54;
  localparam logic [3:0] IpVersion4 = 4'd4;
  localparam logic [5:0] MaxPrefix = 6'd32;

  localparam logic [2:0] ReasonUnchecked = 3'd0;
  localparam logic [2:0] ReasonFlow = 3'd1;
  localparam logic [2:0] ReasonReverse = 3'd2;
  localparam logic [2:0] ReasonNewFlow = 3'd3;
  localparam logic [2:0] ReasonNoRule = 3'd4;
  localparam logic [2:0] ReasonMismatch = 3'd5;
  localparam logic [2:0] ReasonFull = 3'd6;
  localparam logic [2:0] ReasonWritten = 3'd7;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FLOW, S_FLOW_END, S_RULE, S_RULE_END, S_ACT, S_CHK, S_DONE
  } state_t;

  function automatic logic [31:0] prefix_mask(input logic [5:0] plen);
    prefix_mask = ~(32'hFFFF_FFFF >> plen);
  endfunction
endpackage
`default_nettype wire

>>> design/eff_ram.sv
`default_nettype none
module eff_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> design/egress_flow_filter.sv
// Channel | Dir | Handshake            | Beat
// in_     | in  | in_valid / in_ready  | command plus header fields or rule fields
// out_    | out | out_valid / out_ready| verdict, reason
// After reset a clear pass over max(RULE_SLOTS, FLOW_SLOTS) slots runs; in_ready is low.
// Rule writes and short-circuited packets pass through S_DONE to the output register.
// Full classify: flow walk (forward and reverse in one pass) in S_FLOW and S_FLOW_END,
// rule walk in S_RULE and S_RULE_END, then S_ACT and S_CHK for action check and insert.
// Every walk is bound by the single read port of each RAM.
// A stalled output holds the block in its final state; no new beat is taken meanwhile.
`default_nettype none
`include "egress_flow_filter_defines.svh"
module egress_flow_filter #(
  parameter int RULE_SLOTS = eff_pkg::RuleSlotsDef,
  parameter int FLOW_SLOTS = eff_pkg::FlowSlotsDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_cmd,
  input  wire logic [15:0] in_frame_len,
  input  wire logic [15:0] in_ethertype,
  input  wire logic [3:0]  in_ip_version,
  input  wire logic [31:0] in_src_ip,
  input  wire logic [31:0] in_dst_ip,
  input  wire logic [7:0]  in_protocol,
  input  wire logic [15:0] in_sport,
  input  wire logic [15:0] in_dst_port,
  input  wire logic [6:0]  in_rule_slot,
  input  wire logic [5:0]  in_rule_prefix_len,
  input  wire logic        in_rule_valid,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_verdict,
  output logic [2:0]       out_reason
);
  import eff_pkg::*;

  localparam int RIdxW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int FIdxW = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
  localparam int MaxSlots = (RULE_SLOTS > FLOW_SLOTS) ? RULE_SLOTS : FLOW_SLOTS;
  localparam int CntW = $clog2(MaxSlots + 1) + 1;

  state_t state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic vld_d_r, vld_d_nxt;
  logic [CntW-1:0] idx_d_r;

  logic [31:0] sip_r, dip_r;
  logic [7:0] proto_r;
  logic [15:0] sp_r, dp_r;

  logic fwd_r, fwd_nxt, rev_r, rev_nxt, free_found_r, free_found_nxt;
  logic [FIdxW-1:0] free_r, free_nxt;
  logic best_found_r, best_found_nxt;
  logic [RIdxW-1:0] best_r, best_nxt;
  logic [5:0] best_len_r, best_len_nxt;

  logic res_verdict_r, res_verdict_nxt;
  logic [2:0] res_reason_r, res_reason_nxt;
  logic out_valid_r, out_valid_nxt, out_verdict_r, out_reason_ld;
  logic [2:0] out_reason_r;

  // RAM ports
  logic rm_we, ra_we, fa_we, fp_we;
  logic [RIdxW-1:0] r_waddr, rm_raddr, ra_raddr;
  logic [FIdxW-1:0] f_waddr, f_raddr;
  logic [38:0] rm_wdata, rm_rdata;
  logic [39:0] ra_wdata, ra_rdata;
  logic [63:0] fa_wdata, fa_rdata;
  logic [40:0] fp_wdata, fp_rdata;

  logic accept, slot_ok, precheck_ok;
  logic [31:0] slot32;
  logic [5:0] plen_sat;
  logic [CntW-1:0] last_flow, last_rule, last_clr;

  assign accept = in_valid && in_ready;
  assign slot32 = 32'(in_rule_slot);
  assign slot_ok = slot32 < 32'(RULE_SLOTS);
  assign plen_sat = (in_rule_prefix_len > MaxPrefix) ? MaxPrefix : in_rule_prefix_len;
  assign precheck_ok = (in_frame_len >= EthMinLen) && (in_ethertype == EthertypeIpv4) &&
                       (in_frame_len >= IpMinLen) && (in_ip_version == IpVersion4) &&
                       (in_frame_len >= L4MinLen);
  assign last_flow = CntW'(FLOW_SLOTS - 1);
  assign last_rule = CntW'(RULE_SLOTS - 1);
  assign last_clr = CntW'(MaxSlots - 1);

  eff_ram #(.Width(39), .Depth(RULE_SLOTS)) u_rule_match (
    .clk(clk), .we(rm_we), .waddr(r_waddr), .wdata(rm_wdata),
    .raddr(rm_raddr), .rdata(rm_rdata));
  eff_ram #(.Width(40), .Depth(RULE_SLOTS)) u_rule_action (
    .clk(clk), .we(ra_we), .waddr(r_waddr), .wdata(ra_wdata),
    .raddr(ra_raddr), .rdata(ra_rdata));
  eff_ram #(.Width(64), .Depth(FLOW_SLOTS)) u_flow_addrs (
    .clk(clk), .we(fa_we), .waddr(f_waddr), .wdata(fa_wdata),
    .raddr(f_raddr), .rdata(fa_rdata));
  eff_ram #(.Width(41), .Depth(FLOW_SLOTS)) u_flow_pp (
    .clk(clk), .we(fp_we), .waddr(f_waddr), .wdata(fp_wdata),
    .raddr(f_raddr), .rdata(fp_rdata));

  // walk compare unit
  logic e_valid, e_fwd, e_rev, r_valid, r_hit, act_ok;
  logic [5:0] r_plen;
  always_comb begin
    e_valid = fp_rdata[40];
    e_fwd = e_valid && fa_rdata[63:32] == sip_r && fa_rdata[31:0] == dip_r &&
            fp_rdata[39:24] == sp_r && fp_rdata[23:8] == dp_r && fp_rdata[7:0] == proto_r;
    e_rev = e_valid && fa_rdata[63:32] == dip_r && fa_rdata[31:0] == sip_r &&
            fp_rdata[39:24] == dp_r && fp_rdata[23:8] == sp_r && fp_rdata[7:0] == proto_r;
    r_valid = rm_rdata[38];
    r_plen = rm_rdata[37:32];
    r_hit = r_valid && (((dip_r ^ rm_rdata[31:0]) & prefix_mask(r_plen)) == 32'd0);
    act_ok = (ra_rdata[39:32] == proto_r) && (sp_r >= ra_rdata[31:16]) &&
             (sp_r <= ra_rdata[15:0]);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (cnt_r == last_clr) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) state_nxt = (in_cmd || !precheck_ok) ? S_DONE : S_FLOW;
      end
      S_FLOW: if (cnt_r == last_flow) state_nxt = S_FLOW_END;
      S_FLOW_END: state_nxt = (fwd_nxt || rev_nxt) ? S_DONE : S_RULE;
      S_RULE: if (cnt_r == last_rule) state_nxt = S_RULE_END;
      S_RULE_END: state_nxt = best_found_nxt ? S_ACT : S_DONE;
      S_ACT: state_nxt = S_CHK;
      S_CHK: state_nxt = S_DONE;
      S_DONE: if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_nxt = cnt_r;
    vld_d_nxt = 1'b0;
    fwd_nxt = fwd_r;
    rev_nxt = rev_r;
    free_found_nxt = free_found_r;
    free_nxt = free_r;
    best_found_nxt = best_found_r;
    best_nxt = best_r;
    best_len_nxt = best_len_r;
    res_verdict_nxt = res_verdict_r;
    res_reason_nxt = res_reason_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_reason_ld = 1'b0;
    in_ready = (state_r == S_IDLE);
    rm_we = 1'b0;
    ra_we = 1'b0;
    fa_we = 1'b0;
    fp_we = 1'b0;
    r_waddr = cnt_r[RIdxW-1:0];
    f_waddr = cnt_r[FIdxW-1:0];
    rm_wdata = '0;
    ra_wdata = {in_protocol, in_sport, in_dst_port};
    fa_wdata = {sip_r, dip_r};
    fp_wdata = '0;
    rm_raddr = cnt_r[RIdxW-1:0];
    ra_raddr = best_r;
    f_raddr = cnt_r[FIdxW-1:0];

    // flow walk results, taken from the registered RAM read with the delayed index idx_d_r
    if (vld_d_r && (state_r == S_FLOW || state_r == S_FLOW_END)) begin
      if (e_fwd) fwd_nxt = 1'b1;
      if (e_rev) rev_nxt = 1'b1;
      if (!e_valid && !free_found_r) begin
        free_found_nxt = 1'b1;
        free_nxt = idx_d_r[FIdxW-1:0];
      end
    end
    // rule walk: strictly longer prefix wins, so ties keep the lower slot
    if (vld_d_r && (state_r == S_RULE || state_r == S_RULE_END)) begin
      if (r_hit && (!best_found_r || r_plen > best_len_r)) begin
        best_found_nxt = 1'b1;
        best_nxt = idx_d_r[RIdxW-1:0];
        best_len_nxt = r_plen;
      end
    end

    case (state_r)
      S_CLEAR: begin
        rm_we = cnt_r < CntW'(RULE_SLOTS);
        fp_we = cnt_r < CntW'(FLOW_SLOTS);
        cnt_nxt = cnt_r + 1'b1;
      end
      S_IDLE: begin
        cnt_nxt = '0;
        fwd_nxt = 1'b0;
        rev_nxt = 1'b0;
        free_found_nxt = 1'b0;
        best_found_nxt = 1'b0;
        best_len_nxt = '0;
        res_verdict_nxt = 1'b0;
        res_reason_nxt = in_cmd ? ReasonWritten : ReasonUnchecked;
        if (accept && in_cmd && slot_ok) begin
          r_waddr = slot32[RIdxW-1:0];
          rm_wdata = {in_rule_valid, plen_sat, in_dst_ip};
          rm_we = 1'b1;
          ra_we = 1'b1;
        end
      end
      S_FLOW: begin
        vld_d_nxt = 1'b1;
        cnt_nxt = (cnt_r == last_flow) ? '0 : cnt_r + 1'b1;
      end
      S_FLOW_END: begin
        cnt_nxt = '0;
        if (fwd_nxt) res_reason_nxt = ReasonFlow;
        else if (rev_nxt) res_reason_nxt = ReasonReverse;
      end
      S_RULE: begin
        vld_d_nxt = 1'b1;
        cnt_nxt = (cnt_r == last_rule) ? '0 : cnt_r + 1'b1;
      end
      S_RULE_END: begin
        ra_raddr = best_nxt;
        if (!best_found_nxt) begin
          res_verdict_nxt = 1'b1;
          res_reason_nxt = ReasonNoRule;
        end
      end
      S_ACT: ;
      S_CHK: begin
        f_waddr = free_r;
        fp_wdata = {1'b1, sp_r, dp_r, proto_r};
        if (!act_ok) begin
          res_verdict_nxt = 1'b1;
          res_reason_nxt = ReasonMismatch;
        end else if (free_found_r) begin
          fa_we = 1'b1;
          fp_we = 1'b1;
          res_reason_nxt = ReasonNewFlow;
        end else begin
          res_reason_nxt = ReasonFull;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_reason_ld = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r <= '0;
      vld_d_r <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_r <= 1'b0;
      rev_r <= 1'b0;
      free_found_r <= 1'b0;
      best_found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      vld_d_r <= vld_d_nxt;
      out_valid_r <= out_valid_nxt;
      fwd_r <= fwd_nxt;
      rev_r <= rev_nxt;
      free_found_r <= free_found_nxt;
      best_found_r <= best_found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_d_r <= cnt_r;
    free_r <= free_nxt;
    best_r <= best_nxt;
    best_len_r <= best_len_nxt;
    res_verdict_r <= res_verdict_nxt;
    res_reason_r <= res_reason_nxt;
    if (accept) begin
      sip_r <= in_src_ip;
      dip_r <= in_dst_ip;
      proto_r <= in_protocol;
      sp_r <= in_sport;
      dp_r <= in_dst_port;
    end
    if (out_reason_ld) begin
      out_verdict_r <= res_verdict_r;
      out_reason_r <= res_reason_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_verdict = out_verdict_r;
  assign out_reason = out_reason_r;

  `EFF_ASSERT_IMPL(a_written_passes, clk, rst_n, out_valid_r && out_reason_r == ReasonWritten, !out_verdict_r)
  `EFF_ASSERT_NEXT(a_clear_once, clk, rst_n, state_r != S_CLEAR, state_r != S_CLEAR)
  `EFF_ASSERT_IMPL(a_insert_has_slot, clk, rst_n, fa_we, free_found_r && state_r == S_CHK)
  `EFF_ASSERT_IMPL(a_ready_idle_only, clk, rst_n, in_ready, state_r == S_IDLE && !fa_we)
endmodule
`default_nettype wire

>>> verif/tb_egress_flow_filter.sv
`default_nettype none
module tb_egress_flow_filter;
  timeunit 1ns;
  timeprecision 1ps;
  import eff_pkg::*;

  localparam int NumRules = 128;
  localparam int NumFlows = 128;
  localparam int NumRandom = 1630;
  localparam int QuietTail = 150;
  localparam logic CmdClassify = 1'b0;
  localparam logic CmdWrite = 1'b1;
  localparam logic Pass = 1'b0;
  localparam logic Drop = 1'b1;
  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;
  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [15:0] EtherIpv6 = 16'h86DD;

  typedef struct packed {
    logic        cmd;
    logic [15:0] frame_len;
    logic [15:0] ethertype;
    logic [3:0]  ip_version;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  protocol;
    logic [15:0] sport;
    logic [15:0] dst_port;
    logic [6:0]  rule_slot;
    logic [5:0]  rule_prefix_len;
    logic        rule_valid;
  } beat_t;

  typedef struct packed {
    logic       verdict;
    logic [2:0] reason;
  } verdict_t;

  typedef struct packed {
    beat_t    b;
    logic     typed;
    verdict_t v;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  beat_t drv = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_verdict;
  logic [2:0] out_reason;

  // predictor state
  logic        ru_valid [NumRules];
  logic [5:0]  ru_plen [NumRules];
  logic [31:0] ru_addr [NumRules];
  logic [7:0]  ru_proto [NumRules];
  logic [15:0] ru_lo [NumRules];
  logic [15:0] ru_hi [NumRules];
  logic        fl_valid [NumFlows];
  logic [31:0] fl_src [NumFlows];
  logic [31:0] fl_dst [NumFlows];
  logic [15:0] fl_sp [NumFlows];
  logic [15:0] fl_dp [NumFlows];
  logic [7:0]  fl_proto [NumFlows];

  verdict_t verdict_q[$];
  beat_t known_flows[$];
  row_t directed_rows[$];
  int accepted = 0;
  int results = 0;
  int errors = 0;
  int reason_seen [8];
  logic quiet = 1'b0;
  logic long_hold_done = 1'b0;
  logic [31:0] dst_pool [6];

  egress_flow_filter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(drv.cmd), .in_frame_len(drv.frame_len), .in_ethertype(drv.ethertype),
    .in_ip_version(drv.ip_version), .in_src_ip(drv.src_ip), .in_dst_ip(drv.dst_ip),
    .in_protocol(drv.protocol), .in_sport(drv.sport), .in_dst_port(drv.dst_port),
    .in_rule_slot(drv.rule_slot), .in_rule_prefix_len(drv.rule_prefix_len),
    .in_rule_valid(drv.rule_valid),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_verdict(out_verdict), .out_reason(out_reason)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic tuple_in_table(input logic [31:0] s, input logic [31:0] d,
                                          input logic [15:0] sp, input logic [15:0] dp,
                                          input logic [7:0] pr);
    for (int i = 0; i < NumFlows; i++)
      if (fl_valid[i] && fl_src[i] == s && fl_dst[i] == d && fl_sp[i] == sp &&
          fl_dp[i] == dp && fl_proto[i] == pr) return 1'b1;
    return 1'b0;
  endfunction

  // Updates the tables and returns the verdict for one accepted beat.
  function automatic verdict_t filter_verdict(input beat_t b);
    verdict_t r;
    int best;
    logic [31:0] mask;
    r.verdict = Pass;
    best = -1;
    if (b.cmd == CmdWrite) begin
      ru_valid[b.rule_slot] = b.rule_valid;
      ru_plen[b.rule_slot] = (b.rule_prefix_len > 6'd32) ? 6'd32 : b.rule_prefix_len;
      ru_addr[b.rule_slot] = b.dst_ip;
      ru_proto[b.rule_slot] = b.protocol;
      ru_lo[b.rule_slot] = b.sport;
      ru_hi[b.rule_slot] = b.dst_port;
      r.reason = ReasonWritten;
      return r;
    end
    if (b.frame_len < 16'd54 || b.ethertype != 16'h0800 || b.ip_version != 4'd4) begin
      r.reason = ReasonUnchecked;
      return r;
    end
    if (tuple_in_table(b.src_ip, b.dst_ip, b.sport, b.dst_port, b.protocol)) begin
      r.reason = ReasonFlow;
      return r;
    end
    if (tuple_in_table(b.dst_ip, b.src_ip, b.dst_port, b.sport, b.protocol)) begin
      r.reason = ReasonReverse;
      return r;
    end
    for (int i = 0; i < NumRules; i++) begin
      if (!ru_valid[i]) continue;
      mask = (ru_plen[i] == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - ru_plen[i]));
      if (((b.dst_ip ^ ru_addr[i]) & mask) != 0) continue;
      if (best < 0 || ru_plen[i] > ru_plen[best]) best = i;
    end
    r.verdict = Drop;
    if (best < 0) begin
      r.reason = ReasonNoRule;
      return r;
    end
    if (ru_proto[best] != b.protocol || b.sport < ru_lo[best] ||
        b.sport > ru_hi[best]) begin
      r.reason = ReasonMismatch;
      return r;
    end
    r.verdict = Pass;
    for (int i = 0; i < NumFlows; i++) begin
      if (!fl_valid[i]) begin
        fl_valid[i] = 1'b1;
        fl_src[i] = b.src_ip;
        fl_dst[i] = b.dst_ip;
        fl_sp[i] = b.sport;
        fl_dp[i] = b.dst_port;
        fl_proto[i] = b.protocol;
        known_flows.push_back(b);
        r.reason = ReasonNewFlow;
        return r;
      end
    end
    r.reason = ReasonFull;
    return r;
  endfunction

  function automatic beat_t mk_pkt(input logic [15:0] len, input logic [15:0] et,
                                   input logic [3:0] ver, input logic [31:0] sip,
                                   input logic [31:0] dip, input logic [7:0] pr,
                                   input logic [15:0] sp, input logic [15:0] dp);
    beat_t b;
    b = '0;
    b.cmd = CmdClassify;
    b.frame_len = len;
    b.ethertype = et;
    b.ip_version = ver;
    b.src_ip = sip;
    b.dst_ip = dip;
    b.protocol = pr;
    b.sport = sp;
    b.dst_port = dp;
    return b;
  endfunction

  function automatic beat_t mk_rule(input logic [6:0] slot, input logic [5:0] plen,
                                    input logic vld, input logic [31:0] addr,
                                    input logic [7:0] pr, input logic [15:0] lo,
                                    input logic [15:0] hi);
    beat_t b;
    b = mk_pkt(16'd0, 16'd0, 4'd0, 32'd0, addr, pr, lo, hi);
    b.cmd = CmdWrite;
    b.rule_slot = slot;
    b.rule_prefix_len = plen;
    b.rule_valid = vld;
    return b;
  endfunction

  function automatic row_t row(input beat_t b, input logic typed, input logic v,
                               input logic [2:0] r);
    row_t x;
    x.b = b;
    x.typed = typed;
    x.v.verdict = v;
    x.v.reason = r;
    return x;
  endfunction

  function automatic logic [7:0] pick_proto();
    case ($urandom_range(0, 3))
      0: return ProtoTcp;
      1: return ProtoUdp;
      2: return ProtoIcmp;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic beat_t random_beat();
    beat_t b;
    beat_t f;
    logic [15:0] a;
    logic [15:0] c;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      a = 16'($urandom);
      c = 16'($urandom);
      if ($urandom_range(0, 4) != 0 && a > c) {a, c} = {c, a};
      b = mk_rule(7'($urandom_range(0, 3) == 0 ? $urandom_range(0, 127) : $urandom_range(0, 15)),
                  6'($urandom_range(0, 7) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 32)),
                  $urandom_range(0, 6) != 0,
                  dst_pool[$urandom_range(0, 5)] ^ 32'($urandom_range(0, 255) << $urandom_range(0, 24)),
                  pick_proto(), a, c);
      b.src_ip = $urandom;
      b.frame_len = 16'($urandom);
      b.ethertype = 16'($urandom);
      b.ip_version = 4'($urandom);
    end else if (sel < 22) begin
      b = beat_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      b.cmd = CmdClassify;
    end else if (sel < 50 && known_flows.size() > 0) begin
      f = known_flows[$urandom_range(0, known_flows.size() - 1)];
      b = f;
      b.frame_len = 16'($urandom_range(54, 65535));
      if ($urandom_range(0, 1)) begin
        b.src_ip = f.dst_ip;
        b.dst_ip = f.src_ip;
        b.sport = f.dst_port;
        b.dst_port = f.sport;
      end
      if ($urandom_range(0, 5) == 0) b.protocol = pick_proto();
    end else begin
      b = mk_pkt(16'($urandom_range(0, 9) == 0 ? 65535 : $urandom_range(54, 1514)),
                 16'h0800, 4'd4, $urandom,
                 dst_pool[$urandom_range(0, 5)] ^ 32'($urandom_range(0, 65535)),
                 pick_proto(), 16'($urandom), 16'($urandom));
      b.rule_slot = 7'($urandom);
      b.rule_prefix_len = 6'($urandom);
      b.rule_valid = 1'($urandom);
    end
    return b;
  endfunction

  task automatic send(input beat_t b, input logic typed, input verdict_t typed_v);
    verdict_t p;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    drv <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    p = filter_verdict(b);
    verdict_q.push_back(typed ? typed_v : p);
    accepted++;
  endtask

  initial begin
    for (int i = 0; i < NumRules; i++) ru_valid[i] = 1'b0;
    for (int i = 0; i < NumFlows; i++) fl_valid[i] = 1'b0;
    for (int i = 0; i < 6; i++) dst_pool[i] = $urandom;
    for (int i = 0; i < 8; i++) reason_seen[i] = 0;

    directed_rows.push_back(row(mk_pkt(16'd0, 16'h0800, 4'd4, 32'h0, 32'h0, 8'd0, 16'd0, 16'd0),
                                1'b1, Pass, ReasonUnchecked));
    directed_rows.push_back(row(mk_pkt(16'd13, 16'h0800, 4'd4, 32'h1, 32'h2, ProtoTcp, 16'd1,
                                16'd2), 1'b1, Pass, ReasonUnchecked));
    directed_rows.push_back(row(mk_pkt(16'd14, EtherIpv6, 4'd4, 32'h1, 32'h2, ProtoTcp, 16'd1,
                                16'd2), 1'b1, Pass, ReasonUnchecked));
    directed_rows.push_back(row(mk_pkt(16'd33, 16'h0800, 4'd4, 32'h1, 32'h2, ProtoTcp, 16'd1,
                                16'd2), 1'b1, Pass, ReasonUnchecked));
    directed_rows.push_back(row(mk_pkt(16'd53, 16'h0800, 4'd4, 32'h1, 32'h2, ProtoTcp, 16'd1,
                                16'd2), 1'b1, Pass, ReasonUnchecked));
    directed_rows.push_back(row(mk_pkt(16'd54, 16'h0800, 4'd6, 32'h1, 32'h2, ProtoTcp, 16'd1,
                                16'd2), 1'b1, Pass, ReasonUnchecked));
    directed_rows.push_back(row(mk_pkt(16'hFFFF, 16'h0800, 4'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                8'hFF, 16'hFFFF, 16'hFFFF), 1'b1, Drop, ReasonNoRule));
    directed_rows.push_back(row(mk_rule(7'd0, 6'd0, 1'b1, 32'h0, ProtoTcp, 16'd100, 16'd200),
                                1'b1, Pass, ReasonWritten));
    // prefix above 32 saturates
    directed_rows.push_back(row(mk_rule(7'd127, 6'd63, 1'b1, 32'hFFFF_FFFF, ProtoUdp, 16'd0,
                                16'hFFFF), 1'b1, Pass, ReasonWritten));
    directed_rows.push_back(row(mk_pkt(16'd54, 16'h0800, 4'd4, 32'h0102_0304, 32'hFFFF_FFFF,
                                ProtoUdp, 16'd0, 16'd53), 1'b0, Pass, ReasonUnchecked));
    directed_rows.push_back(row(mk_pkt(16'd54, 16'h0800, 4'd4, 32'h0102_0304, 32'hFFFF_FFFF,
                                ProtoUdp, 16'd0, 16'd53), 1'b0, Pass, ReasonUnchecked));
    directed_rows.push_back(row(mk_pkt(16'd60, 16'h0800, 4'd4, 32'hFFFF_FFFF, 32'h0102_0304,
                                ProtoUdp, 16'd53, 16'd0), 1'b0, Pass, ReasonUnchecked));
    directed_rows.push_back(row(mk_pkt(16'd100, 16'h0800, 4'd4, 32'h0A00_0001, 32'h0102_0304,
                                ProtoTcp, 16'd150, 16'd80), 1'b0, Pass, ReasonUnchecked));
    directed_rows.push_back(row(mk_pkt(16'd100, 16'h0800, 4'd4, 32'h0A00_0001, 32'h0102_0304,
                                ProtoTcp, 16'd99, 16'd80), 1'b0, Pass, ReasonUnchecked));
    directed_rows.push_back(row(mk_pkt(16'd100, 16'h0800, 4'd4, 32'h0A00_0001, 32'h0102_0304,
                                ProtoUdp, 16'd150, 16'd80), 1'b0, Pass, ReasonUnchecked));
    // inverted port range never matches
    directed_rows.push_back(row(mk_rule(7'd5, 6'd8, 1'b1, 32'h0A00_0000, ProtoTcp, 16'd300,
                                16'd200), 1'b1, Pass, ReasonWritten));
    directed_rows.push_back(row(mk_pkt(16'd64, 16'h0800, 4'd4, 32'h0B00_0001, 32'h0A01_0203,
                                ProtoTcp, 16'd250, 16'd22), 1'b0, Pass, ReasonUnchecked));
    directed_rows.push_back(row(mk_rule(7'd5, 6'd8, 1'b0, 32'h0A00_0000, ProtoTcp, 16'd300,
                                16'd200), 1'b1, Pass, ReasonWritten));
    directed_rows.push_back(row(mk_pkt(16'd64, 16'h0800, 4'd4, 32'h0B00_0001, 32'h0A01_0203,
                                ProtoTcp, 16'd150, 16'd22), 1'b0, Pass, ReasonUnchecked));
    // equal prefixes: lower slot decides
    directed_rows.push_back(row(mk_rule(7'd10, 6'd16, 1'b1, 32'hC0A8_0000, ProtoTcp, 16'd0,
                                16'd10), 1'b1, Pass, ReasonWritten));
    directed_rows.push_back(row(mk_rule(7'd11, 6'd16, 1'b1, 32'hC0A8_0000, ProtoTcp, 16'd0,
                                16'hFFFF), 1'b1, Pass, ReasonWritten));
    directed_rows.push_back(row(mk_pkt(16'd64, 16'h0800, 4'd4, 32'h0B00_0002, 32'hC0A8_1234,
                                ProtoTcp, 16'd50, 16'd443), 1'b0, Pass, ReasonUnchecked));
    directed_rows.push_back(row(mk_pkt(16'd64, 16'h0800, 4'd4, 32'h0B00_0002, 32'hC0A8_1234,
                                ProtoTcp, 16'd5, 16'd443), 1'b0, Pass, ReasonUnchecked));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[i]) send(directed_rows[i].b, directed_rows[i].typed,
                                    directed_rows[i].v);
    for (int i = 0; i < NumRandom; i++) begin
      if (i >= NumRandom - QuietTail) quiet = 1'b1;
      send(random_beat(), 1'b0, '0);
    end
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("%0d beats sent, %0d results checked; reasons 0..7 seen: %0d %0d %0d %0d %0d %0d %0d %0d",
             accepted, results, reason_seen[0], reason_seen[1], reason_seen[2], reason_seen[3],
             reason_seen[4], reason_seen[5], reason_seen[6], reason_seen[7]);
    $display("flow table entries at end: %0d", known_flows.size());
    if (errors == 0) $display("egress_flow_filter verification clean");
    else $display("egress_flow_filter verification failed");
    $finish;
  end

  // receiver: random stalls, one long hold so the block backs up its input
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!long_hold_done && accepted > 300) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (2000) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    verdict_t w;
    if (rst_n && out_valid && out_ready) begin
      results++;
      reason_seen[out_reason]++;
      if (verdict_q.size() == 0) begin
        $error("result with nothing pending: verdict %0d reason %0d", out_verdict, out_reason);
        errors++;
      end else begin
        w = verdict_q.pop_front();
        if (out_verdict !== w.verdict) begin
          $error("verdict: expected %0d, got %0d", w.verdict, out_verdict);
          errors++;
        end
        if (out_reason !== w.reason) begin
          $error("reason: expected %0d, got %0d", w.reason, out_reason);
          errors++;
        end
      end
    end
  end

  initial begin
    #30_000_000;
    $display("egress_flow_filter verification failed");
    $finish;
  end
endmodule
`default_nettype wire
